// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue; no dependencies.
package spq_pkg;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic req_load;
        logic exec;
    } cmd_t;

endpackage

// ===== design/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue: request intake,
// execution timing and the result valid flag. Depends on spq_pkg.
module spq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output spq_pkg::cmd_t cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic            out_free;

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.req_load = 1'b0;
        cmd.exec     = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == spq_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == spq_pkg::ST_EXEC)
        else $error("Accepted request did not enter execution.");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("Executed request produced no result.");

    a_blocked_exec_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == spq_pkg::ST_EXEC && !out_free |=> state_reg == spq_pkg::ST_EXEC)
        else $error("Execution left while the result register was occupied.");

    a_no_exec_while_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && cmd.exec))
        else $error("Execution overlapped request intake.");
`endif

endmodule

// ===== design/spq_datapath.sv =====
// Datapath of the sorted priority queue: request register, shifting row of
// slots with per-slot compare, entry count, tail register and result register.
// Depends on spq_pkg.
module spq_datapath #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spq_pkg::cmd_t                cmd,
    input  logic [spq_pkg::MODE_W-1:0]   s_mode,
    input  logic [spq_pkg::DATA_W-1:0]   s_priority_req,
    input  logic [spq_pkg::DATA_W-1:0]   s_tag,
    output logic                         m_ok,
    output logic [spq_pkg::COUNT_W-1:0]  m_entry_count,
    output logic [spq_pkg::DATA_W-1:0]   m_head_tag,
    output logic [spq_pkg::DATA_W-1:0]   m_head_priority,
    output logic [spq_pkg::DATA_W-1:0]   m_tail_tag
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::MODE_W-1:0]  mode_reg;
    logic [spq_pkg::DATA_W-1:0]  pri_reg;
    logic [spq_pkg::DATA_W-1:0]  tag_reg;

    logic [spq_pkg::DATA_W-1:0]  slot_pri_reg  [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  slot_tag_reg  [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  slot_pri_next [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  slot_tag_next [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  up_pri        [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  up_tag        [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  dn_pri        [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  dn_tag        [QUEUE_DEPTH];

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [spq_pkg::DATA_W-1:0]  tail_reg;
    logic [spq_pkg::DATA_W-1:0]  tail_next;

    logic                        ok_reg;
    logic [spq_pkg::COUNT_W-1:0] entry_count_reg;
    logic [spq_pkg::DATA_W-1:0]  head_tag_reg;
    logic [spq_pkg::DATA_W-1:0]  head_pri_reg;
    logic [spq_pkg::DATA_W-1:0]  tail_tag_reg;
    logic                        ok_next;

    logic [QUEUE_DEPTH-1:0]      below;
    logic [QUEUE_DEPTH-1:0]      goes_before;
    logic [QUEUE_DEPTH-1:0]      at_end;
    logic [QUEUE_DEPTH-1:0]      shift_zone;
    logic [QUEUE_DEPTH-1:0]      prev_zone;
    logic                        is_full;
    logic                        is_empty;
    logic                        do_insert;
    logic                        do_remove;
    logic                        ins_at_end;

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            mode_reg <= s_mode;
            pri_reg  <= s_priority_req;
            tag_reg  <= s_tag;
        end
    end

    always_comb begin
        is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
        is_empty = (count_reg == '0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            below[i]  = (CNT_W'(i) < count_reg);
            at_end[i] = (CNT_W'(i) == count_reg);
            if (i == 0) begin
                goes_before[i] = (slot_pri_reg[i] > pri_reg);
            end else begin
                goes_before[i] = (slot_pri_reg[i] >= pri_reg);
            end
            shift_zone[i] = (below[i] && goes_before[i]) || at_end[i];
        end
        prev_zone  = shift_zone << 1;
        ins_at_end = ~|(below & goes_before);

        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            up_pri[i] = slot_pri_reg[i];
            up_tag[i] = slot_tag_reg[i];
            dn_pri[i] = slot_pri_reg[i];
            dn_tag[i] = slot_tag_reg[i];
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            up_pri[i] = slot_pri_reg[i + 1];
            up_tag[i] = slot_tag_reg[i + 1];
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            dn_pri[i] = slot_pri_reg[i - 1];
            dn_tag[i] = slot_tag_reg[i - 1];
        end

        do_insert = cmd.exec && (mode_reg == spq_pkg::MODE_INSERT) && !is_full;
        do_remove = cmd.exec && (mode_reg == spq_pkg::MODE_REMOVE) && !is_empty;

        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_pri_next[i] = slot_pri_reg[i];
            slot_tag_next[i] = slot_tag_reg[i];
            if (do_insert) begin
                if (prev_zone[i]) begin
                    slot_pri_next[i] = dn_pri[i];
                    slot_tag_next[i] = dn_tag[i];
                end else if (shift_zone[i]) begin
                    slot_pri_next[i] = pri_reg;
                    slot_tag_next[i] = tag_reg;
                end
            end else if (do_remove) begin
                slot_pri_next[i] = up_pri[i];
                slot_tag_next[i] = up_tag[i];
            end
        end

        count_next = count_reg;
        tail_next  = tail_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
            if (ins_at_end) begin
                tail_next = tag_reg;
            end
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end

        unique case (mode_reg)
            spq_pkg::MODE_INSERT: ok_next = !is_full;
            spq_pkg::MODE_REMOVE: ok_next = !is_empty;
            default:              ok_next = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_pri_reg[i] <= slot_pri_next[i];
            slot_tag_reg[i] <= slot_tag_next[i];
        end
        tail_reg <= tail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            ok_reg          <= ok_next;
            entry_count_reg <= spq_pkg::COUNT_W'(count_next);
            if (count_next == '0) begin
                head_tag_reg <= '0;
                head_pri_reg <= '0;
                tail_tag_reg <= '0;
            end else begin
                head_tag_reg <= slot_tag_next[0];
                head_pri_reg <= slot_pri_next[0];
                tail_tag_reg <= tail_next;
            end
        end
    end

    assign m_ok            = ok_reg;
    assign m_entry_count   = entry_count_reg;
    assign m_head_tag      = head_tag_reg;
    assign m_head_priority = head_pri_reg;
    assign m_tail_tag      = tail_tag_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_W'(2) |-> slot_pri_reg[0] <= slot_pri_reg[1])
        else $error("Head and second entry are out of order.");
`endif

endmodule

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus shifting-slot datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  Channel  Ports                                         Direction  Moves
//  request  s_valid s_ready s_mode s_priority_req s_tag   in         one operation
//  result   m_valid m_ready m_ok m_entry_count m_head_tag out        one status report
//           m_head_priority m_tail_tag
//
// Each request is first captured in the request register; then, in execution,
// the row of slots compares and shifts in parallel and loads the result register.
// A new request is accepted only after the previous one has executed.
// If a result is still waiting, the next request is captured and then holds in
// execution until the result register is free.
// Reset (aresetn, synchronous, active low) empties the queue.
module sorted_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [spq_pkg::MODE_W-1:0]   s_mode,
    input  logic [spq_pkg::DATA_W-1:0]   s_priority_req,
    input  logic [spq_pkg::DATA_W-1:0]   s_tag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [spq_pkg::COUNT_W-1:0]  m_entry_count,
    output logic [spq_pkg::DATA_W-1:0]   m_head_tag,
    output logic [spq_pkg::DATA_W-1:0]   m_head_priority,
    output logic [spq_pkg::DATA_W-1:0]   m_tail_tag
);

    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_mode          (s_mode),
        .s_priority_req  (s_priority_req),
        .s_tag           (s_tag),
        .m_ok            (m_ok),
        .m_entry_count   (m_entry_count),
        .m_head_tag      (m_head_tag),
        .m_head_priority (m_head_priority),
        .m_tail_tag      (m_tail_tag)
    );

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// Testbench for sorted_priority_queue: drives insert, remove, read and unused-mode requests
// and checks every status report against a shadow copy of the sorted slot row.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_REQUESTS = 1500;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] entry_count;
        logic [DATA_W-1:0]  head_tag;
        logic [DATA_W-1:0]  head_priority;
        logic [DATA_W-1:0]  tail_tag;
    } queue_status_t;

    class status_tracker;
        queue_status_t   expected_status[$];
        bit [DATA_W-1:0] pri_row[DEPTH];
        bit [DATA_W-1:0] tag_row[DEPTH];
        int unsigned     held;
        int unsigned     mismatch_count;

        function new();
            held = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] pri,
                                   logic [DATA_W-1:0] tg);
            queue_status_t st;
            int unsigned   pos;
            int unsigned   k;
            st.ok = 1'b1;
            if (mode == MODE_INSERT) begin
                if (held >= DEPTH) begin
                    st.ok = 1'b0;
                end else begin
                    if (held == 0 || pri_row[0] > pri) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held && pri_row[pos] < pri) pos++;
                    end
                    for (k = held; k > pos; k--) begin
                        pri_row[k] = pri_row[k-1];
                        tag_row[k] = tag_row[k-1];
                    end
                    pri_row[pos] = pri;
                    tag_row[pos] = tg;
                    held++;
                end
            end else if (mode == MODE_REMOVE) begin
                if (held == 0) begin
                    st.ok = 1'b0;
                end else begin
                    for (k = 0; k + 1 < held; k++) begin
                        pri_row[k] = pri_row[k+1];
                        tag_row[k] = tag_row[k+1];
                    end
                    held--;
                end
            end
            st.entry_count = held[COUNT_W-1:0];
            if (held == 0) begin
                st.head_tag = '0;
                st.head_priority = '0;
                st.tail_tag = '0;
            end else begin
                st.head_tag = tag_row[0];
                st.head_priority = pri_row[0];
                st.tail_tag = tag_row[held-1];
            end
            expected_status.push_back(st);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("mismatch: %s", what);
        endtask

        task check_status(queue_status_t got);
            queue_status_t want;
            if (expected_status.size() == 0) begin
                report_mismatch("status report with no request pending");
            end else begin
                want = expected_status.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              got.entry_count, want.entry_count));
                if (got.head_tag !== want.head_tag)
                    report_mismatch($sformatf("head_tag got %h want %h",
                                              got.head_tag, want.head_tag));
                if (got.head_priority !== want.head_priority)
                    report_mismatch($sformatf("head_priority got %h want %h",
                                              got.head_priority, want.head_priority));
                if (got.tail_tag !== want.tail_tag)
                    report_mismatch($sformatf("tail_tag got %h want %h",
                                              got.tail_tag, want.tail_tag));
            end
        endtask
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode = MODE_READ;
    logic [DATA_W-1:0]   s_priority_req = '0;
    logic [DATA_W-1:0]   s_tag = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic [COUNT_W-1:0]  m_entry_count;
    logic [DATA_W-1:0]   m_head_tag;
    logic [DATA_W-1:0]   m_head_priority;
    logic [DATA_W-1:0]   m_tail_tag;

    bit                  steady_flow = 1'b0;
    int unsigned         cycle_count = 0;
    status_tracker       tracker;

    sorted_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_priority_req  (s_priority_req),
        .s_tag           (s_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_entry_count   (m_entry_count),
        .m_head_tag      (m_head_tag),
        .m_head_priority (m_head_priority),
        .m_tail_tag      (m_tail_tag)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid === 1'b1 && m_ready)
                tracker.check_status({m_ok, m_entry_count, m_head_tag, m_head_priority,
                                      m_tail_tag});
            m_ready <= steady_flow || ($urandom_range(0, 99) >= 13);
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] pri,
                                input logic [DATA_W-1:0] tg);
        int unsigned gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_priority_req <= pri;
        s_tag <= tg;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_request(mode, pri, tg);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    initial begin
        int unsigned     insert_share;
        int unsigned     pick;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] pri;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(MODE_READ, 16'h0000, 16'h0000);
        send_request(MODE_REMOVE, 16'hFFFF, 16'hFFFF);
        send_request(MODE_UNUSED, 16'h1234, 16'h4321);
        send_request(MODE_INSERT, 16'h8000, 16'hFFFF);
        send_request(MODE_INSERT, 16'h8000, 16'h0001);
        send_request(MODE_INSERT, 16'hFFFF, 16'h0002);
        send_request(MODE_INSERT, 16'h0000, 16'h0000);
        send_request(MODE_INSERT, 16'h8000, 16'h0003);
        send_request(MODE_INSERT, 16'h0000, 16'h5555);
        send_request(MODE_INSERT, 16'hFFFF, 16'hAAAA);
        for (int unsigned n = 0; n < 9; n++)
            send_request(MODE_INSERT, 16'h1C71 * n[15:0], 16'h0100 + n[15:0]);
        send_request(MODE_INSERT, 16'h0001, 16'hBEEF);
        send_request(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(MODE_REMOVE, 16'h0000, 16'h0000);
        send_request(MODE_READ, 16'hFFFF, 16'h0000);

        insert_share = 75;
        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_share = 80;
                    1: insert_share = 20;
                    default: insert_share = 50;
                endcase
            end
            if (i == 300) steady_flow <= 1'b1;
            if (i == 650) steady_flow <= 1'b0;
            if (i % 400 == 399) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 6) mode = MODE_READ;
            else if (pick < 9) mode = MODE_UNUSED;
            else if ($urandom_range(0, 99) < insert_share) mode = MODE_INSERT;
            else mode = MODE_REMOVE;
            case ($urandom_range(0, 5))
                0: pri = 16'h0000;
                1: pri = 16'hFFFF;
                2, 3: pri = 16'($urandom_range(0, 15));
                default: pri = 16'($urandom);
            endcase
            send_request(mode, pri, 16'($urandom));
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (tracker.mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
